/* design/kced_pkg.sv */
// shared types, constants and key decode for the key click event detector
package kced_pkg;

    localparam int NUM_KEYS = 4;
    localparam int KEYS_W   = 4;
    localparam int KEY_W    = 3;
    localparam int KIND_W   = 2;
    localparam int CNT_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS   = 2'd2;

    localparam logic [KEYS_W-1:0] DOUBLE_MASK_RST = 4'd0;
    localparam logic [CNT_W-1:0]  LONG_TICKS_RST  = 16'd80;
    localparam logic [CNT_W-1:0]  GAP_TICKS_RST   = 16'd25;
    localparam logic [CNT_W-1:0]  CNT_MAX         = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_DEBOUNCE = 3'd1,
        PH_HELD     = 3'd2,
        PH_LONG     = 3'd3,
        PH_GAP      = 3'd4,
        PH_SECOND   = 3'd5,
        PH_DOUBLE   = 3'd6
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_SHORT  = 2'd0,
        KIND_LONG   = 2'd1,
        KIND_DOUBLE = 2'd2
    } kind_t;

    typedef struct packed {
        logic                 valid;
        logic [KEY_W-1:0]     key;
        kind_t                kind;
    } event_t;

    // lowest set bit wins, zero when no key is down
    function automatic logic [KEY_W-1:0] decode_keys(input logic [KEYS_W-1:0] bits);
        logic [KEY_W-1:0] k;
        k = '0;
        for (int i = NUM_KEYS - 1; i >= 0; i--)
        begin
            if (bits[i])
            begin
                k = KEY_W'(i + 1);
            end
        end
        return k;
    endfunction

endpackage

/* design/kced_fsm.sv */
// key tracking state machine: phase, held key and tick counter, event decision
module kced_fsm (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [kced_pkg::KEYS_W-1:0]   keys,
    input  logic [kced_pkg::KEYS_W-1:0]   double_mask,
    input  logic [kced_pkg::CNT_W-1:0]    long_ticks,
    input  logic [kced_pkg::CNT_W-1:0]    gap_ticks,
    output kced_pkg::event_t              ev
);

    kced_pkg::phase_t                 phase_reg, phase_next;
    logic [kced_pkg::KEY_W-1:0]       held_reg, held_next;
    logic [kced_pkg::CNT_W-1:0]       count_reg, count_next;

    logic [kced_pkg::KEY_W-1:0]       k;
    logic [kced_pkg::CNT_W-1:0]       count_inc;
    logic                             same_key;
    logic                             no_key;
    logic                             dbl_en;
    logic                             long_hit;
    logic                             gap_hit;

    always_comb
    begin
        k         = kced_pkg::decode_keys(keys);
        same_key  = (k == held_reg);
        no_key    = (k == '0);
        count_inc = (count_reg == kced_pkg::CNT_MAX) ? count_reg : count_reg + 1'b1;
        long_hit  = (count_inc >= long_ticks);
        gap_hit   = (count_inc >= gap_ticks);
        dbl_en    = 1'b0;
        for (int i = 0; i < kced_pkg::NUM_KEYS; i++)
        begin
            if (held_reg == kced_pkg::KEY_W'(i + 1) && double_mask[i])
            begin
                dbl_en = 1'b1;
            end
        end
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        count_next = count_reg;
        unique case (phase_reg)
            kced_pkg::PH_DEBOUNCE:
            begin
                if (same_key)
                begin
                    phase_next = kced_pkg::PH_HELD;
                    count_next = '0;
                end
                else
                begin
                    phase_next = kced_pkg::PH_IDLE;
                end
            end
            kced_pkg::PH_HELD:
            begin
                if (same_key)
                begin
                    count_next = count_inc;
                    if (long_hit)
                    begin
                        phase_next = kced_pkg::PH_LONG;
                    end
                end
                else if (no_key)
                begin
                    count_next = '0;
                    phase_next = dbl_en ? kced_pkg::PH_GAP : kced_pkg::PH_IDLE;
                end
                else
                begin
                    held_next  = k;
                    phase_next = kced_pkg::PH_DEBOUNCE;
                end
            end
            kced_pkg::PH_LONG, kced_pkg::PH_DOUBLE:
            begin
                if (no_key)
                begin
                    phase_next = kced_pkg::PH_IDLE;
                end
                else if (!same_key)
                begin
                    held_next  = k;
                    phase_next = kced_pkg::PH_DEBOUNCE;
                end
            end
            kced_pkg::PH_GAP:
            begin
                if (no_key)
                begin
                    count_next = count_inc;
                    if (gap_hit)
                    begin
                        phase_next = kced_pkg::PH_IDLE;
                    end
                end
                else if (same_key)
                begin
                    phase_next = kced_pkg::PH_SECOND;
                end
                else
                begin
                    held_next  = k;
                    phase_next = kced_pkg::PH_DEBOUNCE;
                end
            end
            kced_pkg::PH_SECOND:
            begin
                phase_next = same_key ? kced_pkg::PH_DOUBLE : kced_pkg::PH_GAP;
            end
            default:
            begin
                phase_next = kced_pkg::PH_IDLE;
                if (!no_key)
                begin
                    held_next  = k;
                    phase_next = kced_pkg::PH_DEBOUNCE;
                end
            end
        endcase
    end

    // event for this tick, always for the key held before the tick
    always_comb
    begin
        ev.valid = 1'b0;
        ev.key   = held_reg;
        ev.kind  = kced_pkg::KIND_SHORT;
        unique case (phase_reg)
            kced_pkg::PH_HELD:
            begin
                if (same_key)
                begin
                    ev.valid = long_hit;
                    ev.kind  = kced_pkg::KIND_LONG;
                end
                else if (no_key)
                begin
                    ev.valid = !dbl_en;
                end
                else
                begin
                    ev.valid = 1'b1;
                end
            end
            kced_pkg::PH_GAP:
            begin
                if (no_key)
                begin
                    ev.valid = gap_hit;
                end
                else if (!same_key)
                begin
                    ev.valid = 1'b1;
                end
            end
            kced_pkg::PH_SECOND:
            begin
                ev.valid = same_key;
                ev.kind  = kced_pkg::KIND_DOUBLE;
            end
            default:
            begin
                ev.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= kced_pkg::PH_IDLE;
            held_reg  <= '0;
            count_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            count_reg <= count_next;
        end
    end

endmodule

/* design/key_click_event_detector.sv */
// top level: config registers, input stage, key state machine and result register
// One scan tick per request, one request per cycle when the result side keeps up.
// A tick is captured in an input register and evaluated when it leaves that stage, and
// its event is then registered in the result register before it shows; each tick
// yields at most one event (short click, long press or double click). The rate is set
// by the state update of the key state machine, one per advancing tick. A stall on the result side
// holds the pending event and, once the input stage is full, stalls the input side.
// Configuration is written through cfg_we/cfg_index/cfg_data while no ticks are in
// flight; writes to an index beyond the register list are ignored.
module key_click_event_detector (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [kced_pkg::KEYS_W-1:0]       keys_pressed,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [kced_pkg::KEY_W-1:0]        event_key,
    output logic [kced_pkg::KIND_W-1:0]       event_kind,
    input  logic                              cfg_we,
    input  logic [kced_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kced_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [kced_pkg::KEYS_W-1:0]  mask_reg;
    logic [kced_pkg::CNT_W-1:0]   long_reg;
    logic [kced_pkg::CNT_W-1:0]   gap_reg;

    logic                         stage_valid_reg, stage_valid_next;
    logic [kced_pkg::KEYS_W-1:0]  stage_keys_reg;
    logic                         out_valid_reg, out_valid_next;
    logic [kced_pkg::KEY_W-1:0]   event_key_reg;
    kced_pkg::kind_t              event_kind_reg;

    logic                         advance;
    logic                         accept;
    kced_pkg::event_t             ev;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= kced_pkg::DOUBLE_MASK_RST;
            long_reg <= kced_pkg::LONG_TICKS_RST;
            gap_reg  <= kced_pkg::GAP_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                kced_pkg::REG_DOUBLE_MASK: mask_reg <= cfg_data[kced_pkg::KEYS_W-1:0];
                kced_pkg::REG_LONG_TICKS:  long_reg <= cfg_data[kced_pkg::CNT_W-1:0];
                kced_pkg::REG_GAP_TICKS:   gap_reg  <= cfg_data[kced_pkg::CNT_W-1:0];
                default:                   ;
            endcase
        end
    end

    // the staged tick moves on whenever the result register is free or draining
    assign advance  = stage_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = stage_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (advance)
        begin
            stage_valid_next = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg;
        end

        if (advance)
        begin
            out_valid_next = ev.valid;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    kced_fsm u_fsm (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .keys        (stage_keys_reg),
        .double_mask (mask_reg),
        .long_ticks  (long_reg),
        .gap_ticks   (gap_reg),
        .ev          (ev)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_keys_reg <= keys_pressed;
        end
        if (advance && ev.valid)
        begin
            event_key_reg  <= ev.key;
            event_kind_reg <= ev.kind;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_key  = event_key_reg;
    assign event_kind = event_kind_reg;

endmodule
